/* rtl/core/gwm_pkg.sv */
// Shared constants and types for the glob wildcard matcher.
// Holds the configuration register map, the special pattern bytes and the input word type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

	localparam int DEFAULT_MAX_PATTERN_BYTES = 32;

	localparam int CHAR_W        = 8;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 3;
	localparam int BYTES_PER_REG = CFG_DATA_W / CHAR_W;
	localparam int LEN_REG_W     = 6;

	localparam logic [CHAR_W-1:0] STAR_BYTE     = 8'h2A;
	localparam logic [CHAR_W-1:0] QUESTION_BYTE = 8'h3F;
	localparam logic [CHAR_W-1:0] DOT_BYTE      = 8'h2E;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_0 = 3'd0,
		REG_PATTERN_1 = 3'd1,
		REG_PATTERN_2 = 3'd2,
		REG_PATTERN_3 = 3'd3,
		REG_LENGTH    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              end_of_string;
	} word_t;

endpackage

`default_nettype wire

/* rtl/core/gwm_pattern_regs.sv */
// Pattern and length configuration registers of the glob wildcard matcher.
// Decodes the per-position byte, star and in-range flags; depends on gwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwm_pattern_regs #(
	parameter int MAX_PATTERN_BYTES = gwm_pkg::DEFAULT_MAX_PATTERN_BYTES,
	localparam int PosW = $clog2(MAX_PATTERN_BYTES + 1)
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           cfg_write,
	input  wire logic [gwm_pkg::CFG_INDEX_W-1:0]                cfg_index,
	input  wire logic [gwm_pkg::CFG_DATA_W-1:0]                 cfg_data,
	output logic [MAX_PATTERN_BYTES-1:0][gwm_pkg::CHAR_W-1:0]   pat_bytes,
	output logic [MAX_PATTERN_BYTES-1:0]                        is_star,
	output logic [MAX_PATTERN_BYTES-1:0]                        in_range,
	output logic [MAX_PATTERN_BYTES:0]                          keep,
	output logic [PosW-1:0]                                     eff_len
);

	localparam int IdxW = gwm_pkg::CFG_INDEX_W;
	localparam int LenW = gwm_pkg::LEN_REG_W;
	localparam int ChW  = gwm_pkg::CHAR_W;

	logic [ChW-1:0]  pat_q [MAX_PATTERN_BYTES];
	logic [LenW-1:0] len_q;

	for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_byte
		localparam int WordSel = i / gwm_pkg::BYTES_PER_REG;
		localparam int ByteSel = i % gwm_pkg::BYTES_PER_REG;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pat_q[i] <= '0;
			end else if (cfg_write && cfg_index == IdxW'(WordSel)) begin
				pat_q[i] <= cfg_data[ByteSel*ChW +: ChW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_write && cfg_index == gwm_pkg::REG_LENGTH) begin
			len_q <= cfg_data[LenW-1:0];
		end
	end

	// Lengths above the configured maximum saturate.
	assign eff_len = (len_q > LenW'(MAX_PATTERN_BYTES)) ? PosW'(MAX_PATTERN_BYTES)
	                                                     : len_q[PosW-1:0];

	always_comb begin
		for (int p = 0; p < MAX_PATTERN_BYTES; p++) begin
			pat_bytes[p] = pat_q[p];
			is_star[p]   = (pat_q[p] == gwm_pkg::STAR_BYTE);
			in_range[p]  = (PosW'(p) < eff_len);
		end
		for (int p = 0; p <= MAX_PATTERN_BYTES; p++) begin
			keep[p] = (PosW'(p) <= eff_len);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/gwm_closure.sv */
// Star closure of a position set: drops positions past the pattern end and
// adds every position reachable over a run of stars, as a parallel prefix.
// Depends on gwm_pkg for the default pattern size.
`timescale 1ns / 1ps
`default_nettype none

module gwm_closure #(
	parameter int MAX_PATTERN_BYTES = gwm_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
	input  wire logic [MAX_PATTERN_BYTES:0]   set_in,
	input  wire logic [MAX_PATTERN_BYTES-1:0] star_en,
	input  wire logic [MAX_PATTERN_BYTES:0]   keep,
	output logic [MAX_PATTERN_BYTES:0]        set_out
);

	localparam int Levels = $clog2(MAX_PATTERN_BYTES + 1);

	// Bit j of the propagate vector says a position can pass on to j through a star at j-1.
	always_comb begin
		logic [MAX_PATTERN_BYTES:0] gen;
		logic [MAX_PATTERN_BYTES:0] prop;
		logic [MAX_PATTERN_BYTES:0] gen_nx;
		logic [MAX_PATTERN_BYTES:0] prop_nx;
		gen  = set_in & keep;
		prop = {star_en, 1'b0};
		for (int lv = 0; lv < Levels; lv++) begin
			gen_nx  = gen;
			prop_nx = prop;
			for (int j = 0; j <= MAX_PATTERN_BYTES; j++) begin
				if (j >= (1 << lv)) begin
					gen_nx[j]  = gen[j] | (prop[j] & gen[j - (1 << lv)]);
					prop_nx[j] = prop[j] & prop[j - (1 << lv)];
				end
			end
			gen  = gen_nx;
			prop = prop_nx;
		end
		set_out = gen;
	end

endmodule

`default_nettype wire

/* rtl/core/gwm_advance.sv */
// One character step of the position set: a star keeps its position, a
// matching byte or question mark moves to the next one. Depends on gwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwm_advance #(
	parameter int MAX_PATTERN_BYTES = gwm_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
	input  wire logic [MAX_PATTERN_BYTES:0]                        cur,
	input  wire logic [gwm_pkg::CHAR_W-1:0]                        character,
	input  wire logic [MAX_PATTERN_BYTES-1:0][gwm_pkg::CHAR_W-1:0] pat_bytes,
	input  wire logic [MAX_PATTERN_BYTES-1:0]                      is_star,
	input  wire logic [MAX_PATTERN_BYTES-1:0]                      in_range,
	output logic [MAX_PATTERN_BYTES:0]                             next
);

	logic [MAX_PATTERN_BYTES-1:0] stay;
	logic [MAX_PATTERN_BYTES-1:0] hit;
	logic                         any_ok;

	assign any_ok = (character != gwm_pkg::DOT_BYTE);

	always_comb begin
		for (int p = 0; p < MAX_PATTERN_BYTES; p++) begin
			stay[p] = cur[p] & in_range[p] & is_star[p];
			hit[p]  = cur[p] & in_range[p] & ~is_star[p]
			        & ((pat_bytes[p] == character)
			        || (pat_bytes[p] == gwm_pkg::QUESTION_BYTE && any_ok));
		end
	end

	assign next = {1'b0, stay} | {hit, 1'b0};

endmodule

`default_nettype wire

/* rtl/core/glob_wildcard_matcher.sv */
// Glob wildcard matcher top level: input register, position tracker and result register.
// Instantiates gwm_pattern_regs, gwm_closure and gwm_advance; depends on gwm_pkg.
//
// The string arrives on the input channel one word per character, ended by a
// word with end_of_string set, whose character is ignored. The output channel
// carries one word per string: matched is set when the whole string matches
// the whole pattern. A star matches any run of characters, a question mark
// any one character except a dot, and every other byte only itself.
// The pattern and its length are written through the configuration port
// between words; a change applies from the next word on.
// A word is accepted in every cycle in which the input does not stall. The
// result of an end word is presented from the result register, loaded as that
// word leaves the input register; the work per word is one pass through the
// two star-closure prefix networks and the byte compares around the position
// register. The result register lets the next string stream in while a result
// waits; input stalls only when an end word is held behind an unread result.
// Reset clears the pattern to zero length and arms the tracker at the start
// position; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module glob_wildcard_matcher #(
	parameter int MAX_PATTERN_BYTES = gwm_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [gwm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [gwm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [gwm_pkg::CHAR_W-1:0]        character,
	input  wire logic                              end_of_string,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   matched
);

	localparam int PosW = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int ChW  = gwm_pkg::CHAR_W;

	logic [MAX_PATTERN_BYTES-1:0][ChW-1:0] pat_bytes;
	logic [MAX_PATTERN_BYTES-1:0]          is_star;
	logic [MAX_PATTERN_BYTES-1:0]          in_range;
	logic [MAX_PATTERN_BYTES-1:0]          star_en;
	logic [MAX_PATTERN_BYTES:0]            keep;
	logic [PosW-1:0]                       eff_len;

	gwm_pkg::word_t                        word_s1;
	logic                                  word_valid_s1;
	logic                                  advance;
	logic                                  accept;

	logic [MAX_PATTERN_BYTES:0]            reach_q;
	logic [MAX_PATTERN_BYTES:0]            cur;
	logic [MAX_PATTERN_BYTES:0]            stepped;
	logic [MAX_PATTERN_BYTES:0]            closed;
	logic                                  out_valid_q;
	logic                                  matched_q;

	gwm_pattern_regs #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pat_bytes(pat_bytes),
		.is_star  (is_star),
		.in_range (in_range),
		.keep     (keep),
		.eff_len  (eff_len)
	);

	assign star_en = is_star & in_range;

	gwm_closure #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_close_cur (
		.set_in (reach_q),
		.star_en(star_en),
		.keep   (keep),
		.set_out(cur)
	);

	gwm_advance #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_advance (
		.cur      (cur),
		.character(word_s1.character),
		.pat_bytes(pat_bytes),
		.is_star  (is_star),
		.in_range (in_range),
		.next     (stepped)
	);

	gwm_closure #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_close_next (
		.set_in (stepped),
		.star_en(star_en),
		.keep   (keep),
		.set_out(closed)
	);

	assign advance  = word_valid_s1 && (!word_s1.end_of_string || !out_valid_q || !out_stall);
	assign in_stall = word_valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_s1 <= 1'b0;
		end else if (accept) begin
			word_valid_s1 <= 1'b1;
		end else if (advance) begin
			word_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.character     <= character;
			word_s1.end_of_string <= end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= (MAX_PATTERN_BYTES + 1)'(1);
		end else if (advance) begin
			if (word_s1.end_of_string) begin
				reach_q <= (MAX_PATTERN_BYTES + 1)'(1);
			end else begin
				reach_q <= closed;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_s1.end_of_string) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.end_of_string) begin
			matched_q <= cur[eff_len];
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

endmodule

`default_nettype wire
